@@ rtl/spdd_pkg.sv @@
// spdd_pkg: shared widths, register index codes and bundle types for the
// steering pid differential drive block
// no dependencies
package spdd_pkg;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int ERR_W      = 17;   // setpoint - sample, exact
   localparam int EP_W       = 18;   // e0 - e1
   localparam int ED_W       = 19;   // e0 - 2*e1 + e2
   localparam int ADJ_W      = 16;
   localparam int SPEED_W    = 17;

   // product and sum widths
   localparam int PROD_P_W   = GAIN_W + EP_W;
   localparam int PROD_I_W   = GAIN_W + ERR_W;
   localparam int PROD_D_W   = GAIN_W + ED_W;
   localparam int SUM_W      = PROD_D_W + 2;

   // ports
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAIN_PROP  = 3'd0,
      CSR_GAIN_INTEG = 3'd1,
      CSR_GAIN_DERIV = 3'd2,
      CSR_OUT_LIMIT  = 3'd3,
      CSR_SETPOINT   = 3'd4,
      CSR_BASE_SPEED = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop;
      logic signed [GAIN_W-1:0] integ;
      logic signed [GAIN_W-1:0] deriv;
   } gain_type;

   typedef struct packed {
      logic signed [PROD_P_W-1:0] prop;
      logic signed [PROD_I_W-1:0] integ;
      logic signed [PROD_D_W-1:0] deriv;
   } prod_type;

endpackage

@@ rtl/spdd_err.sv @@
// spdd_err: sample input register, error history and gain product register
// depends on spdd_pkg
module spdd_err (
   input  logic                                clock,
   input  logic                                reset,
   input  spdd_pkg::gain_type                  gains,
   input  logic signed [spdd_pkg::SAMPLE_W-1:0] setpoint,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [spdd_pkg::SAMPLE_W-1:0] in_sample,
   output logic                                prod_valid,
   input  logic                                prod_ready,
   output spdd_pkg::prod_type                  prod
);
   import spdd_pkg::*;

   logic                       smp_valid_ff, smp_valid_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [ERR_W-1:0]    err1_ff, err1_in;
   logic signed [ERR_W-1:0]    err2_ff, err2_in;
   logic                       prod_valid_ff, prod_valid_in;
   prod_type                   prod_ff, prod_in;

   logic                       en_smp, en_prod, advance;
   logic signed [ERR_W-1:0]    e0;
   logic signed [EP_W-1:0]     ep;
   logic signed [ED_W-1:0]     ed;

   // stage enables: a stage loads when empty or when its content moves on
   assign en_prod  = !prod_valid_ff || prod_ready;
   assign en_smp   = !smp_valid_ff || en_prod;
   assign advance  = smp_valid_ff && en_prod;
   assign in_ready = en_smp;

   always_comb begin
      e0 = ERR_W'(setpoint) - ERR_W'(sample_ff);
      ep = EP_W'(e0) - EP_W'(err1_ff);
      ed = ED_W'(e0) - (ED_W'(err1_ff) <<< 1) + ED_W'(err2_ff);

      prod_in.prop  = gains.prop  * ep;
      prod_in.integ = gains.integ * e0;
      prod_in.deriv = gains.deriv * ed;

      smp_valid_in  = en_smp ? in_valid : smp_valid_ff;
      prod_valid_in = en_prod ? smp_valid_ff : prod_valid_ff;
      err1_in       = advance ? e0 : err1_ff;
      err2_in       = advance ? err1_ff : err2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         err1_ff       <= '0;
         err2_ff       <= '0;
      end else begin
         smp_valid_ff  <= smp_valid_in;
         prod_valid_ff <= prod_valid_in;
         err1_ff       <= err1_in;
         err2_ff       <= err2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_smp && in_valid) begin
         sample_ff <= in_sample;
      end
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

@@ rtl/spdd_mix.sv @@
// spdd_mix: sum of products, floor shift, saturation and wheel speed mixing
// into the result register; depends on spdd_pkg
module spdd_mix #(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic        [spdd_pkg::LIMIT_W-1:0]  out_limit,
   input  logic signed [spdd_pkg::SAMPLE_W-1:0] base_speed,
   input  logic                                 prod_valid,
   output logic                                 prod_ready,
   input  spdd_pkg::prod_type                   prod,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [spdd_pkg::ADJ_W-1:0]    out_adj,
   output logic signed [spdd_pkg::SPEED_W-1:0]  out_left,
   output logic signed [spdd_pkg::SPEED_W-1:0]  out_right
);
   import spdd_pkg::*;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ADJ_W-1:0]   adj_ff, adj_in;
   logic signed [SPEED_W-1:0] left_ff, left_in;
   logic signed [SPEED_W-1:0] right_ff, right_in;

   logic                      load;
   logic signed [SUM_W-1:0]   sum, sum_sh, lim_pos, lim_neg;

   assign prod_ready = !rsp_valid_ff || out_ready;
   assign load       = prod_ready && prod_valid;

   always_comb begin
      sum = SUM_W'($signed(prod.prop)) + SUM_W'($signed(prod.integ))
          + SUM_W'($signed(prod.deriv));
      // arithmetic shift floors toward minus infinity
      sum_sh  = sum >>> GAIN_FRAC_BITS;
      lim_pos = $signed(SUM_W'(out_limit));
      lim_neg = -lim_pos;
      if (sum_sh > lim_pos) begin
         adj_in = ADJ_W'(lim_pos);
      end else if (sum_sh < lim_neg) begin
         adj_in = ADJ_W'(lim_neg);
      end else begin
         adj_in = ADJ_W'(sum_sh);
      end
      left_in      = SPEED_W'(base_speed) + SPEED_W'(adj_in);
      right_in     = SPEED_W'(base_speed) - SPEED_W'(adj_in);
      rsp_valid_in = prod_ready ? prod_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         adj_ff   <= adj_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_adj   = adj_ff;
   assign out_left  = left_ff;
   assign out_right = right_ff;

endmodule

@@ rtl/steering_pid_differential_drive.sv @@
// steering_pid_differential_drive: incremental pid steering controller with
// differential wheel mixing; top level with control registers
// depends on spdd_pkg, spdd_err, spdd_mix
// an accepted req beat passes through the sample, product and result registers
// in that order to its rsp beat; throughput: one sample per cycle while rsp_tready
// holds, set by the three-stage register pipeline
// reset: synchronous, active high; clears pipeline valids and error history,
// loads register defaults (gains 4096/2048/410, limit 300, setpoint 0, base 50)
module steering_pid_differential_drive #(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // control register write port
   input  logic                                  csr_wen,
   input  logic [spdd_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [spdd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // sample stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [spdd_pkg::SAMPLE_W-1:0]         req_tdata,  // [15:0] position_sample
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [15:0] adjustment, [32:16] left_speed, [49:33] right_speed, [55:50] zero
   output logic [spdd_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import spdd_pkg::*;

   // control registers
   gain_type                   gains_ff;
   logic        [LIMIT_W-1:0]  out_limit_ff;
   logic signed [SAMPLE_W-1:0] setpoint_ff;
   logic signed [SAMPLE_W-1:0] base_speed_ff;

   // error stage to mix stage
   logic                       prod_valid, prod_ready;
   prod_type                   prod;

   logic signed [ADJ_W-1:0]    adj;
   logic signed [SPEED_W-1:0]  left_speed, right_speed;

   // register writes; unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop  <= 16'sd4096;
         gains_ff.integ <= 16'sd2048;
         gains_ff.deriv <= 16'sd410;
         out_limit_ff   <= 15'd300;
         setpoint_ff    <= '0;
         base_speed_ff  <= 16'sd50;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            CSR_GAIN_PROP:  gains_ff.prop  <= $signed(csr_wdata);
            CSR_GAIN_INTEG: gains_ff.integ <= $signed(csr_wdata);
            CSR_GAIN_DERIV: gains_ff.deriv <= $signed(csr_wdata);
            CSR_OUT_LIMIT:  out_limit_ff   <= csr_wdata[LIMIT_W-1:0];
            CSR_SETPOINT:   setpoint_ff    <= $signed(csr_wdata);
            CSR_BASE_SPEED: base_speed_ff  <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // error forming, history and gain products
   spdd_err u_err (
      .clock      (clock),
      .reset      (reset),
      .gains      (gains_ff),
      .setpoint   (setpoint_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  ($signed(req_tdata)),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   // sum, floor shift, clamp and wheel mixing
   spdd_mix #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_mix (
      .clock      (clock),
      .reset      (reset),
      .out_limit  (out_limit_ff),
      .base_speed (base_speed_ff),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_adj    (adj),
      .out_left   (left_speed),
      .out_right  (right_speed)
   );

   // pack result beat, lowest field first
   assign rsp_tdata = {
      (RSP_DATA_W - ADJ_W - 2*SPEED_W)'(0), right_speed, left_speed, adj
   };

   // adjustment never leaves the configured band
   a_adj_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(adj) <= $signed({1'b0, out_limit_ff})
                   && $signed(adj) >= -$signed({1'b0, out_limit_ff})))
      else $error("adjustment outside saturation band");

   // wheel speeds stay symmetric around base speed
   a_speed_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (18'(left_speed) + 18'(right_speed)
                      == 18'(base_speed_ff) + 18'(base_speed_ff)))
      else $error("wheel speeds not symmetric around base");

   // pipeline is empty on the first cycle out of reset
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid && !prod_valid)
      else $error("pipeline not empty after reset");

endmodule
